// ===== src/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: status codes,
// controller states, and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Pool layout
   localparam int WORD_BYTES      = 8;
   localparam int BLOCK_BYTES     = 16;
   localparam int SLOTS_PER_GROUP = 64;
   localparam int STRIDE          = WORD_BYTES + SLOTS_PER_GROUP * BLOCK_BYTES;
   localparam int POOL_RESET      = 4096;

   // Reciprocal for (r >> 3) / 129, exact for dividends (r >> 3) below 2**21
   localparam int RECIP       = 16257;
   localparam int RECIP_SHIFT = 21;

   // Rows of group full flags searched as one unit
   localparam int ROW_BITS = 32;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_SIZE  = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_PICK_ROW,
      S_PICK_GROUP,
      S_READ,
      S_EVAL,
      S_COMMIT,
      S_REPLY
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       mul;
      logic       decode;
      logic       pick_row;
      logic       pick_group;
      logic       eval;
      logic       alloc_wr;
      logic       free_wr;
      logic       reply;
      status_type reply_code;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic over_count;
      logic addr_bad;
      logic decode_bad;
      logic all_full;
      logic past_end;
      logic word_zero;
      logic rsp_free;
   } dp_stat_type;

   // Index of the lowest clear bit of a row of full flags
   function automatic logic [4:0] lowest_zero32(input logic [ROW_BITS-1:0] w);
      logic [4:0] idx;
      idx = '0;
      for (int i = ROW_BITS - 1; i >= 0; i--) begin
         if (!w[i]) idx = 5'(i);
      end
      return idx;
   endfunction

   // Index of the lowest clear bit of an occupancy word
   function automatic logic [5:0] lowest_zero64(input logic [63:0] w);
      logic [5:0] idx;
      idx = '0;
      for (int i = 63; i >= 0; i--) begin
         if (!w[i]) idx = 6'(i);
      end
      return idx;
   endfunction

endpackage

// ===== src/bba_req_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: allocate or free command with its operands.
// ----------------------------------------------------------------------------
interface bba_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] request_size;
   logic [16:0] address;

   modport source (output valid, kind, request_size, address, input ready);
   modport sink   (input valid, kind, request_size, address, output ready);
endinterface

// ===== src/bba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: status code and allocated block offset.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
   import bba_pkg::*;

   logic        valid;
   logic        ready;
   status_type  status;
   logic [16:0] block_offset;

   modport source (output valid, status, block_offset, input ready);
   modport sink   (input valid, status, block_offset, output ready);
endinterface

// ===== src/bba_csr_if.sv =====
// ----------------------------------------------------------------------------
// bba_csr_if
// Configuration write channel carrying the pool size register.
// ----------------------------------------------------------------------------
interface bba_csr_if;
   logic        valid;
   logic        ready;
   logic [16:0] pool_bytes;

   modport source (output valid, pool_bytes, input ready);
   modport sink   (input valid, pool_bytes, output ready);
endinterface

// ===== src/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for one request at a time: checks, group search or address
// decode, occupancy word read, then commit and response.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bba_pkg::dp_stat_type stat,
   output bba_pkg::ctl_cmd_type cmd
);
   import bba_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Error code held for the reply state
   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.is_free) begin
               if (stat.addr_bad) begin
                  state_in = S_REPLY;
                  code_in  = ST_NOT_FOUND;
               end else begin
                  state_in = S_DIVIDE;
               end
            end else begin
               priority if (stat.bad_size) begin
                  state_in = S_REPLY;
                  code_in  = ST_BAD_SIZE;
               end else if (stat.over_count) begin
                  state_in = S_REPLY;
                  code_in  = ST_NO_SPACE;
               end else begin
                  state_in = S_PICK_ROW;
               end
            end
         end
         S_DIVIDE: begin
            if (stat.decode_bad) begin
               state_in = S_REPLY;
               code_in  = ST_NOT_FOUND;
            end else begin
               state_in = S_READ;
            end
         end
         S_PICK_ROW: begin
            if (stat.all_full) begin
               state_in = S_REPLY;
               code_in  = ST_NO_SPACE;
            end else begin
               state_in = S_PICK_GROUP;
            end
         end
         S_PICK_GROUP: state_in = S_READ;
         S_READ:       state_in = S_EVAL;
         S_EVAL:       state_in = S_COMMIT;
         S_COMMIT: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         S_REPLY: begin
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      cmd.reply_code = ST_OK;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_CHECK:      cmd.mul        = 1'b1;
         S_DIVIDE:     cmd.decode     = 1'b1;
         S_PICK_ROW:   cmd.pick_row   = 1'b1;
         S_PICK_GROUP: cmd.pick_group = 1'b1;
         S_READ:       ;
         S_EVAL:       cmd.eval       = 1'b1;
         S_COMMIT: begin
            cmd.reply = stat.rsp_free;
            if (stat.is_free) begin
               if (stat.word_zero) begin
                  cmd.reply_code = ST_NOT_FOUND;
               end else begin
                  cmd.free_wr = stat.rsp_free;
               end
            end else begin
               if (stat.past_end) begin
                  cmd.reply_code = ST_NO_SPACE;
               end else begin
                  cmd.alloc_wr = stat.rsp_free;
               end
            end
         end
         S_REPLY: begin
            cmd.reply      = stat.rsp_free;
            cmd.reply_code = code_ff;
         end
         default: ;
      endcase
   end

endmodule

// ===== src/bba_datapath.sv =====
// ----------------------------------------------------------------------------
// bba_datapath
// Request registers, pool size and used count, occupancy word memory,
// per-group full flags with row summaries, free address decode and the
// response register.
// ----------------------------------------------------------------------------
module bba_datapath #(
   parameter int MAX_GROUPS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_kind,
   input  logic [15:0]          req_request_size,
   input  logic [16:0]          req_address,
   input  logic                 csr_valid,
   input  logic [16:0]          csr_pool_bytes,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output bba_pkg::status_type  rsp_status,
   output logic [16:0]          rsp_block_offset,
   input  bba_pkg::ctl_cmd_type cmd,
   output bba_pkg::dp_stat_type stat
);
   import bba_pkg::*;

   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int FW    = $clog2(MAX_GROUPS + 1);
   localparam int NROW  = (MAX_GROUPS + ROW_BITS - 1) / ROW_BITS;
   localparam int RW    = (NROW > 1) ? $clog2(NROW) : 1;
   localparam int PIW   = $clog2(NROW * ROW_BITS);
   localparam int SW    = $clog2(MAX_GROUPS * STRIDE + 1);
   localparam int EW    = ((SW > 17) ? SW : 17) + 1;
   localparam int QW    = 14;
   localparam int PW    = QW + 14;

   // Request and configuration registers
   logic              kind_ff;
   logic [15:0]       size_ff;
   logic [16:0]       addr_ff;
   logic [16:0]       pool_ff;
   logic [16:0]       used_ff;
   logic [FW-1:0]     fill_ff;

   // Search and word registers
   logic [NROW-1:0][ROW_BITS-1:0] full_ff;
   logic [NROW-1:0]   row_full_ff;
   logic [RW-1:0]     row_ff;
   logic [GW-1:0]     group_ff;
   logic [5:0]        slot_ff;
   logic [63:0]       word_ff;
   logic [63:0]       rd_word_ff;
   logic [SW-1:0]     base_ff;
   logic [PW-1:0]     prod_ff;

   // Response register
   logic              rsp_valid_ff;
   status_type        status_ff;
   logic [16:0]       offset_ff;

   logic [63:0]       occ_mem [MAX_GROUPS];

   logic [16:0]       r_w;
   logic [6:0]        gq_w;
   logic [16:0]       within_w;
   logic [RW-1:0]     row_pick;
   logic [4:0]        lane_pick;
   logic [PIW-1:0]    pick_idx;
   logic [PIW-1:0]    wr_idx;
   logic [RW-1:0]     wr_row;
   logic [4:0]        wr_lane;
   logic [63:0]       eval_word;
   logic [63:0]       slot_bit;
   logic [63:0]       new_word;
   logic [EW-1:0]     end_w;
   logic [SW-1:0]     start_w;
   logic              rsp_free;
   logic              word_write;

   // Free address decode: group by reciprocal multiply, slot from remainder
   assign r_w      = addr_ff - 17'(WORD_BYTES);
   assign gq_w     = prod_ff[RECIP_SHIFT +: 7];
   assign within_w = r_w - 17'(gq_w) * 17'(STRIDE);

   // First row that still has a free group
   always_comb begin
      row_pick = '0;
      for (int c = NROW - 1; c >= 0; c--) begin
         if (!row_full_ff[c]) row_pick = RW'(c);
      end
   end

   assign lane_pick = lowest_zero32(full_ff[row_ff]);
   assign pick_idx  = PIW'({row_ff, lane_pick});

   assign wr_idx  = PIW'(group_ff);
   assign wr_row  = RW'(wr_idx >> 5);
   assign wr_lane = wr_idx[4:0];

   // Groups at or past the fill count were never written and read as empty
   assign eval_word = (FW'(group_ff) < fill_ff) ? rd_word_ff : '0;

   assign slot_bit   = 64'(1) << slot_ff;
   assign new_word   = cmd.alloc_wr ? (word_ff | slot_bit) : (word_ff & ~slot_bit);
   assign start_w    = base_ff + SW'({slot_ff, 4'b0000});
   assign end_w      = EW'(start_w) + EW'(BLOCK_BYTES);
   assign word_write = cmd.alloc_wr || (cmd.free_wr && word_ff[slot_ff]);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // Status to the controller
   always_comb begin
      stat            = '0;
      stat.is_free    = (kind_ff == KIND_FREE);
      stat.bad_size   = (size_ff != 16'(BLOCK_BYTES));
      stat.over_count = (18'(used_ff) + 18'(BLOCK_BYTES)) > 18'(pool_ff);
      stat.addr_bad   = (addr_ff < 17'(WORD_BYTES)) || (addr_ff > pool_ff);
      stat.decode_bad = (32'(gq_w) >= MAX_GROUPS) || (within_w[3:0] != 4'd0)
                        || within_w[10];
      stat.all_full   = &row_full_ff;
      stat.past_end   = end_w > EW'(pool_ff);
      stat.word_zero  = (word_ff == '0);
      stat.rsp_free   = rsp_free;
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         size_ff <= req_request_size;
         addr_ff <= req_address;
      end
   end

   // Pool size, used count and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= 17'(POOL_RESET);
         used_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (csr_valid) pool_ff <= csr_pool_bytes;
         if (cmd.alloc_wr) begin
            used_ff <= used_ff + 17'(BLOCK_BYTES);
            if (FW'(group_ff) >= fill_ff) fill_ff <= FW'(group_ff) + FW'(1);
         end else if (cmd.free_wr && word_ff[slot_ff]) begin
            used_ff <= (used_ff >= 17'(BLOCK_BYTES)) ? used_ff - 17'(BLOCK_BYTES) : '0;
         end
      end
   end

   // Group full flags; padding groups past the end count as full
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NROW; c++) begin
            for (int l = 0; l < ROW_BITS; l++) begin
               full_ff[c][l] <= (c * ROW_BITS + l >= MAX_GROUPS);
            end
         end
         row_full_ff <= '0;
      end else begin
         if (word_write) full_ff[wr_row][wr_lane] <= &new_word;
         for (int c = 0; c < NROW; c++) begin
            row_full_ff[c] <= &full_ff[c];
         end
      end
   end

   // Search, decode and evaluate registers
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= PW'(r_w[16:3]) * PW'(RECIP);
      if (cmd.pick_row) row_ff <= row_pick;
      priority if (cmd.decode) begin
         group_ff <= GW'(gq_w);
         slot_ff  <= within_w[9:4];
      end else if (cmd.pick_group) begin
         group_ff <= GW'(pick_idx);
      end else if (cmd.eval) begin
         word_ff <= eval_word;
         base_ff <= SW'(32'(group_ff) * STRIDE + WORD_BYTES);
         if (kind_ff == KIND_ALLOC) slot_ff <= lowest_zero64(eval_word);
      end
   end

   // Occupancy word memory
   always_ff @(posedge clock) begin
      if (word_write) occ_mem[group_ff] <= new_word;
      rd_word_ff <= occ_mem[group_ff];
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.reply) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         status_ff <= cmd.reply_code;
         offset_ff <= cmd.alloc_wr ? 17'(start_w) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_block_offset = offset_ff;

   // A pending response is never overwritten
   a_reply_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.reply |-> rsp_free)
      else $error("response loaded while previous one still pending");

   // Allocation only commits a slot inside the pool of a non-full word
   a_alloc_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_wr |-> (!stat.past_end && !word_ff[slot_ff]))
      else $error("allocation committed to a bad slot");

   // Written groups never run past the group count
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_GROUPS))
      else $error("fill count beyond group count");

   // After an allocate commit the used count has grown by one block
   a_used_step: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_wr |=> used_ff == $past(used_ff) + 17'(BLOCK_BYTES))
      else $error("used count not advanced on allocate");

endmodule

// ===== src/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// Fixed 16-byte block allocator over a pool of groups, each an 8-byte
// occupancy word followed by 64 slots.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transfer: kind 0 allocates a block of
//   request_size bytes (only 16 is accepted), kind 1 frees the block at byte
//   offset address. rsp_chan returns one status/block_offset per command, in
//   order. csr_chan writes pool_bytes and is always ready; the user must write
//   it only while no command is in flight, which the block does not enforce.
//   One command is worked at a time. An allocate that reaches the occupancy
//   word steps through check, row search, group search, word read,
//   evaluate and commit; a free that reaches its word steps through check,
//   address decode, word read, evaluate and commit; a rejected check, decode
//   or row search goes to the reply step. The next command is taken in the
//   idle state that follows the response load; no new command is taken
//   before the previous one's response is loaded.
//   The response sits in an output register; a new command is accepted
//   while it waits. If the receiver stalls, the commit or reply step holds
//   until the register frees up.
//   Reset empties the pool and loads pool_bytes to 4096 at once: a fill
//   count marks never-written groups as empty, so no clearing pass is run.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core #(
   parameter int MAX_GROUPS = 64
) (
   input  logic      clock,
   input  logic      reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan,
   bba_csr_if.sink   csr_chan
);
   import bba_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;
   logic        req_ready;

   // Configuration writes are always accepted
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_datapath #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_chan.kind),
      .req_request_size (req_chan.request_size),
      .req_address      (req_chan.address),
      .csr_valid        (csr_chan.valid),
      .csr_pool_bytes   (csr_chan.pool_bytes),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_status       (rsp_chan.status),
      .rsp_block_offset (rsp_chan.block_offset),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
